FILE: src/mfr_pkg.sv
// mfr_pkg: word types, result codes and register indexes of the fragment
// reassembler; used by mfr_engine and the core, depends on nothing
`default_nettype none

package mfr_pkg;

   localparam int SEQ_W    = 32;
   localparam int POS_W    = 17;
   localparam int SIZE_W   = 24;
   localparam int LEN_W    = 18;
   localparam int COUNT_W  = 32;

   // operation codes
   localparam logic OP_FRAGMENT = 1'b0;
   localparam logic OP_READ     = 1'b1;

   // result status codes
   localparam logic [2:0] ST_PROGRESS  = 3'd0;
   localparam logic [2:0] ST_VIDEO     = 3'd1;
   localparam logic [2:0] ST_AUDIO     = 3'd2;
   localparam logic [2:0] ST_UNKNOWN   = 3'd3;
   localparam logic [2:0] ST_OVERSIZE  = 3'd4;
   localparam logic [2:0] ST_IGNORED   = 3'd5;
   localparam logic [2:0] ST_READ_DATA = 3'd6;

   // configuration register indexes
   localparam logic [1:0] REG_VIDEO_MASK = 2'd0;
   localparam logic [1:0] REG_AUDIO_MASK = 2'd1;
   localparam logic [1:0] REG_MAX_FRAME  = 2'd2;

   localparam logic [7:0]       VIDEO_MASK_RESET = 8'd1;
   localparam logic [7:0]       AUDIO_MASK_RESET = 8'd2;
   localparam logic [LEN_W-1:0] MAX_FRAME_RESET  = 18'd102400;

   typedef struct packed {
      logic              operation;
      logic              first_in_datagram;
      logic              first_of_fragment;
      logic              last_of_fragment;
      logic [7:0]        fragment_kind_bits;
      logic [SEQ_W-1:0]  fragment_sequence;
      logic [POS_W-1:0]  fragment_offset;
      logic [SIZE_W-1:0] whole_frame_size;
      logic [7:0]        payload_byte;
      logic [POS_W-1:0]  read_address;
   } mfr_req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [LEN_W-1:0] frame_length;
      logic [7:0]       read_data;
   } mfr_rsp_type;

   typedef struct packed {
      logic [7:0]       video_mask;
      logic [7:0]       audio_mask;
      logic [LEN_W-1:0] max_frame;
   } mfr_cfg_type;

   // result of one word as decided by the engine, before buffer read data joins it
   typedef struct packed {
      logic [2:0]       status;
      logic [LEN_W-1:0] frame_length;
      logic             is_read;
      logic             read_in_range;
   } mfr_result_type;

endpackage

`default_nettype wire

FILE: src/mfr_ram.sv
// mfr_ram: generic single-write, single-read memory with registered read
// data; no dependencies
`default_nettype none

module mfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/mfr_engine.sv
// mfr_engine: per-word reassembly decisions, sequence and byte counters,
// and buffer access requests; depends on mfr_pkg
`default_nettype none

module mfr_engine
   import mfr_pkg::*;
#(
   parameter int BUFFER_BYTES = 131072
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            accept,
   input  wire mfr_req_type                     req,
   input  wire mfr_cfg_type                     cfg,
   output logic                                 mem_wr_en,
   output logic      [$clog2(BUFFER_BYTES)-1:0] mem_wr_addr,
   output logic      [7:0]                      mem_wr_data,
   output logic                                 mem_rd_en,
   output logic      [$clog2(BUFFER_BYTES)-1:0] mem_rd_addr,
   output mfr_result_type                       result
);

   localparam int AW = $clog2(BUFFER_BYTES);
   // wide enough for any buffer address, the buffer size itself and offset plus position
   localparam int CW = (AW + 1 > POS_W + 1) ? AW + 1 : POS_W + 1;
   localparam logic [CW-1:0] BUF_LIMIT = CW'(BUFFER_BYTES);

   logic [SEQ_W-1:0]   newest_seq_ff, newest_seq_in;
   logic [COUNT_W-1:0] collected_ff, collected_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               skipped_ff, skipped_in;
   logic               ignored_ff, ignored_in;

   logic               ignore_now;
   logic               no_type;
   logic               too_big;
   logic [POS_W-1:0]   pos_base;
   logic               skip_now;
   logic               seq_newer;
   logic [COUNT_W-1:0] coll_base;
   logic [COUNT_W-1:0] coll_next;
   logic [CW-1:0]      wr_addr_ext;
   logic [CW-1:0]      rd_addr_ext;
   logic               frame_done;

   always_comb begin
      ignore_now  = req.first_in_datagram ? 1'b0 : ignored_ff;
      no_type     = ((req.fragment_kind_bits & cfg.video_mask) == 8'd0) &&
                    ((req.fragment_kind_bits & cfg.audio_mask) == 8'd0);
      too_big     = req.whole_frame_size > SIZE_W'(cfg.max_frame);
      seq_newer   = req.fragment_sequence > newest_seq_ff;
      pos_base    = req.first_of_fragment ? '0 : pos_ff;
      skip_now    = req.first_of_fragment ? (req.fragment_sequence < newest_seq_ff)
                                          : skipped_ff;
      coll_base   = (req.first_of_fragment && seq_newer) ? '0 : collected_ff;
      coll_next   = coll_base + COUNT_W'(1);
      frame_done  = req.last_of_fragment &&
                    (coll_next == COUNT_W'(req.whole_frame_size));
      wr_addr_ext = CW'(req.fragment_offset) + CW'(pos_base);
      rd_addr_ext = CW'(req.read_address);

      newest_seq_in = newest_seq_ff;
      collected_in  = collected_ff;
      pos_in        = pos_ff;
      skipped_in    = skipped_ff;
      ignored_in    = ignored_ff;

      mem_wr_en   = 1'b0;
      mem_wr_addr = AW'(wr_addr_ext);
      mem_wr_data = req.payload_byte;
      mem_rd_en   = accept && (req.operation == OP_READ);
      mem_rd_addr = AW'(rd_addr_ext);

      result.status        = ST_PROGRESS;
      result.frame_length  = '0;
      result.is_read       = 1'b0;
      result.read_in_range = rd_addr_ext < BUF_LIMIT;

      if (req.operation == OP_READ) begin
         result.status  = ST_READ_DATA;
         result.is_read = 1'b1;
      end else if (ignore_now) begin
         result.status = ST_IGNORED;
         ignored_in    = 1'b1;
      end else if (req.first_of_fragment && no_type) begin
         result.status = ST_UNKNOWN;
         ignored_in    = 1'b1;
      end else if (req.first_of_fragment && too_big) begin
         result.status = ST_OVERSIZE;
         ignored_in    = 1'b1;
      end else begin
         ignored_in = 1'b0;
         skipped_in = skip_now;
         if (req.first_of_fragment && seq_newer) begin
            newest_seq_in = req.fragment_sequence;
         end
         collected_in = coll_base;
         if (skip_now) begin
            pos_in = pos_base;
         end else begin
            // out-of-buffer bytes are counted but not stored
            mem_wr_en = accept && (wr_addr_ext < BUF_LIMIT);
            pos_in    = pos_base + POS_W'(1);
            if (frame_done) begin
               result.status       = ((req.fragment_kind_bits & cfg.video_mask) != 8'd0) ?
                                     ST_VIDEO : ST_AUDIO;
               result.frame_length = coll_next[LEN_W-1:0];
               collected_in        = '0;
               ignored_in          = 1'b1;
            end else begin
               collected_in = coll_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         newest_seq_ff <= '0;
         collected_ff  <= '0;
         pos_ff        <= '0;
         skipped_ff    <= 1'b0;
         ignored_ff    <= 1'b0;
      end else if (accept && (req.operation == OP_FRAGMENT)) begin
         newest_seq_ff <= newest_seq_in;
         collected_ff  <= collected_in;
         pos_ff        <= pos_in;
         skipped_ff    <= skipped_in;
         ignored_ff    <= ignored_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/media_fragment_reassembler_core.sv
// media_fragment_reassembler_core: one word in per cycle while the output register
// is free or being taken; its result word is offered the cycle after acceptance
// and then waits in the output register.
// Synchronous reset clears counters, sequence, flags and registers to their
// defaults; the frame buffer has no reset and no clearing pass.
// Depends on mfr_pkg, mfr_engine and mfr_ram.
`default_nettype none

module media_fragment_reassembler_core
   import mfr_pkg::*;
#(
   parameter int BUFFER_BYTES = 131072
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mfr_req_type       req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output mfr_rsp_type            rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [1:0]        csr_index,
   input  wire logic [LEN_W-1:0]  csr_wr_data
);

   localparam int AW = $clog2(BUFFER_BYTES);

   mfr_cfg_type    cfg_ff;
   logic           rsp_valid_ff;
   mfr_result_type result_ff;
   mfr_result_type result;
   logic           accept;
   logic           mem_wr_en;
   logic [AW-1:0]  mem_wr_addr;
   logic [7:0]     mem_wr_data;
   logic           mem_rd_en;
   logic [AW-1:0]  mem_rd_addr;
   logic [7:0]     mem_rd_data;

   // the output slot frees as it is taken, so a word enters while the slot is empty or being taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.video_mask <= VIDEO_MASK_RESET;
         cfg_ff.audio_mask <= AUDIO_MASK_RESET;
         cfg_ff.max_frame  <= MAX_FRAME_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_VIDEO_MASK: cfg_ff.video_mask <= csr_wr_data[7:0];
            REG_AUDIO_MASK: cfg_ff.audio_mask <= csr_wr_data[7:0];
            REG_MAX_FRAME:  cfg_ff.max_frame  <= csr_wr_data;
            default: ;
         endcase
      end
   end

   mfr_engine #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_data),
      .cfg         (cfg_ff),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .result      (result)
   );

   mfr_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_BYTES)
   ) u_frame_buffer (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_valid;
      end
      if (accept) begin
         result_ff <= result;
      end
   end

   // ram read data holds until the next read word, which only enters as this one leaves
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_data.status        = result_ff.status;
   assign rsp_data.frame_length  = result_ff.frame_length;
   assign rsp_data.read_data     = (result_ff.is_read && result_ff.read_in_range) ?
                                   mem_rd_data : 8'd0;

endmodule

`default_nettype wire
